// ===== rtl/sevq_pkg.sv =====
// Shared types, constants and helpers for the sorted event queue.
// No dependencies; every other file refers to this package by scoped names.
package sevq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int TIME_BITS   = 32;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // One input request.
    typedef struct packed {
        logic               mode;
        logic [31:0]        event_time;
        logic [1:0]         event_kind;
        logic signed [7:0]  robot_index;
        logic signed [15:0] order_number;
    } t_in_req;

    // One result.
    typedef struct packed {
        logic               popped_valid;
        logic [31:0]        popped_time;
        logic [1:0]         popped_kind;
        logic signed [7:0]  popped_robot;
        logic signed [15:0] popped_order;
        logic               head_valid;
        logic [31:0]        head_time;
        logic [CNT_W-1:0]   stored_count;
        logic               queue_empty;
        logic               insert_dropped;
    } t_out_rsp;

    // Stored event.
    typedef struct packed {
        logic [TIME_BITS-1:0] time_val;
        logic [1:0]           kind;
        logic signed [7:0]    robot;
        logic signed [15:0]   order;
    } t_event;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_POP    = 1'b1
    } t_mode;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_in;
        logic exec;
    } t_ctrl_cmd;

    // Port time (32 bits) to stored time (TIME_BITS): truncate or zero-extend.
    function automatic logic [TIME_BITS-1:0] to_time(input logic [31:0] t);
        logic [TIME_BITS+31:0] w;
        w = '0;
        w[31:0] = t;
        return w[TIME_BITS-1:0];
    endfunction

    // Stored time back to the 32-bit port field.
    function automatic logic [31:0] from_time(input logic [TIME_BITS-1:0] t);
        logic [TIME_BITS+31:0] w;
        w = '0;
        w[TIME_BITS-1:0] = t;
        return w[31:0];
    endfunction

endpackage

// ===== rtl/sevq_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on sevq_pkg for the payload types.
interface sevq_req_if;
    logic              valid;
    logic              ready;
    sevq_pkg::t_in_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sevq_rsp_if;
    logic               valid;
    logic               ready;
    sevq_pkg::t_out_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/sevq_ctrl.sv =====
// Controller: request accept, execute step and result-register valid.
// Depends on sevq_pkg.
module sevq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    output logic                o_rsp_valid,
    input  logic                i_rsp_ready,
    output sevq_pkg::t_ctrl_cmd o_cmd
);

    sevq_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             can_exec;

    assign can_exec = !r_out_valid || i_rsp_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sevq_pkg::S_IDLE: begin
                if (i_req_valid) n_state = sevq_pkg::S_EXEC;
            end
            sevq_pkg::S_EXEC: begin
                if (can_exec) n_state = sevq_pkg::S_IDLE;
            end
            default: n_state = sevq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready   = 1'b0;
        o_cmd.load_in = 1'b0;
        o_cmd.exec    = 1'b0;
        unique case (r_state)
            sevq_pkg::S_IDLE: begin
                o_req_ready   = 1'b1;
                o_cmd.load_in = i_req_valid;
            end
            sevq_pkg::S_EXEC: begin
                o_cmd.exec = can_exec;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sevq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_rsp_valid = r_out_valid;

endmodule

// ===== rtl/sevq_datapath.sv =====
// Datapath: sorted shift array with one compare cell per slot, count,
// request register and result register. Depends on sevq_pkg.
module sevq_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sevq_pkg::t_ctrl_cmd i_cmd,
    input  sevq_pkg::t_in_req   i_req,
    output sevq_pkg::t_out_rsp  o_rsp
);

    sevq_pkg::t_event             r_entry [sevq_pkg::QUEUE_DEPTH];
    logic [sevq_pkg::CNT_W-1:0]   r_count, n_count;
    sevq_pkg::t_in_req            r_in;
    sevq_pkg::t_out_rsp           r_rsp, n_rsp;
    sevq_pkg::t_event             new_ev;
    logic [sevq_pkg::QUEUE_DEPTH-1:0] le;
    logic                         is_pop, full, do_ins, do_pop;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) r_in <= i_req;
    end

    assign new_ev.time_val = sevq_pkg::to_time(r_in.event_time);
    assign new_ev.kind     = r_in.event_kind;
    assign new_ev.robot    = r_in.robot_index;
    assign new_ev.order    = r_in.order_number;

    assign is_pop = (r_in.mode == sevq_pkg::MODE_POP);
    assign full   = (r_count == sevq_pkg::CNT_W'(sevq_pkg::QUEUE_DEPTH));
    assign do_ins = i_cmd.exec && !is_pop && !full;
    assign do_pop = i_cmd.exec && is_pop && (r_count != '0);

    // Compare cells: slot holds a live event not later than the new one.
    // Ascending order makes le a prefix; the insert point is its end.
    genvar g;
    generate
        for (g = 0; g < sevq_pkg::QUEUE_DEPTH; g++) begin : g_cell
            assign le[g] = (sevq_pkg::CNT_W'(g) < r_count)
                        && (r_entry[g].time_val <= new_ev.time_val);
        end
    endgenerate

    // Slots past the insert point shift up by one; a pop shifts all down.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < sevq_pkg::QUEUE_DEPTH; k++) begin
            if (do_ins && !le[k]) begin
                if (k == 0) begin
                    r_entry[k] <= new_ev;
                end else if (le[(k == 0) ? 0 : k-1]) begin
                    r_entry[k] <= new_ev;
                end else begin
                    r_entry[k] <= r_entry[(k == 0) ? 0 : k-1];
                end
            end else if (do_pop && (k < sevq_pkg::QUEUE_DEPTH-1)) begin
                r_entry[k] <= r_entry[(k < sevq_pkg::QUEUE_DEPTH-1) ? k+1 : k];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (do_ins) n_count = r_count + 1'b1;
        else if (do_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_comb begin
        n_rsp = '0;
        n_rsp.stored_count = n_count;
        n_rsp.head_valid   = (n_count != '0);
        n_rsp.queue_empty  = (n_count == '0);
        if (!is_pop) begin
            n_rsp.insert_dropped = full;
            if (full || le[0]) begin
                n_rsp.head_time = sevq_pkg::from_time(r_entry[0].time_val);
            end else begin
                n_rsp.head_time = sevq_pkg::from_time(new_ev.time_val);
            end
        end else if (r_count != '0) begin
            n_rsp.popped_valid = 1'b1;
            n_rsp.popped_time  = sevq_pkg::from_time(r_entry[0].time_val);
            n_rsp.popped_kind  = r_entry[0].kind;
            n_rsp.popped_robot = r_entry[0].robot;
            n_rsp.popped_order = r_entry[0].order;
            if (n_count != '0) begin
                n_rsp.head_time = sevq_pkg::from_time(r_entry[1].time_val);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) r_rsp <= n_rsp;
    end

    assign o_rsp = r_rsp;

endmodule

// ===== rtl/sorted_event_queue.sv =====
// Top level of the sorted event queue: request/result channels, controller
// and datapath. Depends on sevq_pkg, sevq_if, sevq_ctrl and sevq_datapath.
//
// Time-ordered event queue with QUEUE_DEPTH slots. An insert request
// (mode 0) places the event behind every stored event with an equal or
// earlier time, so equal times leave first-in first-out; an insert into a
// full queue is dropped and flagged in insert_dropped. A pop request
// (mode 1) returns the head event with popped_valid set, or popped_valid
// clear on an empty queue. Every request yields exactly one result that
// also carries the head time, count and empty flag after the operation.
// A request is captured first; then, in the execute step, every
// slot compares its time against the new event in parallel and the whole
// array shifts in place. The result sits in an output register, so a new
// request is taken while the previous result waits; the execute cycle
// waits only while that register still holds an untaken result. No
// clearing pass runs: reset clears only the count, state and valid flag.

module sorted_event_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sevq_req_if.sink          i_req,
    sevq_rsp_if.source        o_rsp
);

    sevq_pkg::t_ctrl_cmd cmd;

    // Sequencing: accept, then execute once the result slot is free.
    sevq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    // Storage, compare cells and result formation.
    sevq_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req.payload),
        .o_rsp   (o_rsp.payload)
    );

endmodule
